/* rtl/mwc_pkg.sv */
// mwc_pkg: shared types and constants of the minimum window cover block
// no dependencies; imported by every module of the block
package mwc_pkg;

  localparam int MAX_TEXT_DEF = 4096;
  localparam int SYM_W        = 8;
  localparam int SYM_N        = 1 << SYM_W;
  localparam int MODE_W       = 2;
  localparam int START_W      = 12;
  localparam int LEN_W        = 13;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 32;

  typedef logic [SYM_W-1:0] sym_t;

  // item kinds carried in the low bits of the input beat
  typedef enum logic [MODE_W-1:0] {
    MODE_PATTERN = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_FINISH  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_UPD,
    ST_TXT_UPD,
    ST_SHR_RD,
    ST_SHR_CHK,
    ST_RECORD,
    ST_FINISH
  } seq_state_t;

  // control toward the count table
  typedef struct packed {
    logic wr_en;
    logic clear;
    sym_t addr;
  } cnt_ctl_t;

endpackage

/* rtl/mwc_cnt_tbl.sv */
// mwc_cnt_tbl: need/have count table, one synchronous memory with a
// per-entry valid flag so a job clear resets every entry at once; uses mwc_pkg
module mwc_cnt_tbl import mwc_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF,
  localparam int CNT_W = $clog2(MAX_TEXT + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cnt_ctl_t         ctl,
  input  logic [CNT_W-1:0] wr_need,
  input  logic [CNT_W-1:0] wr_have,
  output logic [CNT_W-1:0] rd_need,
  output logic [CNT_W-1:0] rd_have
);

  logic [2*CNT_W-1:0] mem [SYM_N];
  logic [2*CNT_W-1:0] q_r;
  logic [SYM_N-1:0]   vld_r;
  logic               q_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.addr] <= {wr_need, wr_have};
    end
    q_r <= mem[ctl.addr];
  end

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= vld_r[ctl.addr];
      if (ctl.wr_en) begin
        vld_r[ctl.addr] <= 1'b1;
      end
    end
  end

  assign rd_need = q_vld_r ? q_r[2*CNT_W-1:CNT_W] : '0;
  assign rd_have = q_vld_r ? q_r[CNT_W-1:0]       : '0;

endmodule

/* rtl/mwc_text_buf.sv */
// mwc_text_buf: text byte buffer, one write port and one registered read port
// uses mwc_pkg
module mwc_text_buf import mwc_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF,
  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sym_t          wdata,
  input  logic [AW-1:0] raddr,
  output sym_t          rdata
);

  sym_t mem [MAX_TEXT];
  sym_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mwc_seq.sv */
// mwc_seq: sequencer and window registers; drives the count table and the
// text buffer through read-modify-write steps; uses mwc_pkg
module mwc_seq import mwc_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF,
  localparam int CNT_W = $clog2(MAX_TEXT + 1),
  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [MODE_W-1:0]  in_mode,
  input  sym_t               in_sym,
  output logic               in_ready,
  output cnt_ctl_t           cnt_ctl,
  output logic [CNT_W-1:0]   cnt_wr_need,
  output logic [CNT_W-1:0]   cnt_wr_have,
  input  logic [CNT_W-1:0]   cnt_rd_need,
  input  logic [CNT_W-1:0]   cnt_rd_have,
  output logic               txt_we,
  output logic [AW-1:0]      txt_waddr,
  output sym_t               txt_wdata,
  output logic [AW-1:0]      txt_raddr,
  input  sym_t               txt_rdata,
  output logic               res_valid,
  input  logic               res_take,
  output logic               res_found,
  output logic [START_W-1:0] res_start,
  output logic [LEN_W-1:0]   res_len,
  output logic               res_overflow
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  seq_state_t       state_r, state_nxt;
  sym_t             sym_r, sym_nxt;
  sym_t             shr_sym_r, shr_sym_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] right_r, right_nxt;
  logic [CNT_W-1:0] missing_r, missing_nxt;
  logic [CNT_W-1:0] pat_len_r, pat_len_nxt;
  logic [AW-1:0]    best_start_r, best_start_nxt;
  logic [CNT_W-1:0] best_len_r, best_len_nxt;
  logic             best_valid_r, best_valid_nxt;
  logic             ovf_r, ovf_nxt;

  logic [CNT_W-1:0] left_inc;
  logic [CNT_W-1:0] miss_dec;
  logic [CNT_W-1:0] win_len;
  logic [AW+START_W-1:0]  start_ext;
  logic [CNT_W+LEN_W-1:0] len_ext;

  assign left_inc = left_r + ONE;
  assign win_len  = right_r - left_r;
  assign miss_dec = missing_r - CNT_W'(cnt_rd_have < cnt_rd_need);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sym_r        <= '0;
      shr_sym_r    <= '0;
      left_r       <= '0;
      right_r      <= '0;
      missing_r    <= '0;
      pat_len_r    <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      best_valid_r <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sym_r        <= sym_nxt;
      shr_sym_r    <= shr_sym_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      missing_r    <= missing_nxt;
      pat_len_r    <= pat_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      best_valid_r <= best_valid_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    shr_sym_nxt    = shr_sym_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    missing_nxt    = missing_r;
    pat_len_nxt    = pat_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    best_valid_nxt = best_valid_r;
    ovf_nxt        = ovf_r;

    in_ready      = (state_r == ST_IDLE);
    cnt_ctl.wr_en = 1'b0;
    cnt_ctl.clear = 1'b0;
    cnt_ctl.addr  = sym_r;
    cnt_wr_need   = cnt_rd_need;
    cnt_wr_have   = cnt_rd_have;
    txt_we        = 1'b0;
    txt_waddr     = right_r[AW-1:0];
    txt_wdata     = in_sym;
    txt_raddr     = left_r[AW-1:0];
    res_valid     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        cnt_ctl.addr = in_sym;
        if (in_valid) begin
          case (in_mode)
            MODE_PATTERN: begin
              // pattern bytes after the first text byte are ignored
              if (right_r == '0) begin
                if (pat_len_r >= MAX_CNT) begin
                  ovf_nxt = 1'b1;
                end else begin
                  sym_nxt   = in_sym;
                  state_nxt = ST_PAT_UPD;
                end
              end
            end
            MODE_TEXT: begin
              if (right_r >= MAX_CNT) begin
                ovf_nxt = 1'b1;
              end else begin
                txt_we    = 1'b1;
                right_nxt = right_r + ONE;
                sym_nxt   = in_sym;
                if (pat_len_r != '0) begin
                  state_nxt = ST_TXT_UPD;
                end
              end
            end
            MODE_FINISH: begin
              state_nxt = ST_FINISH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAT_UPD: begin
        cnt_ctl.wr_en = 1'b1;
        cnt_wr_need   = cnt_rd_need + ONE;
        pat_len_nxt   = pat_len_r + ONE;
        missing_nxt   = missing_r + ONE;
        state_nxt     = ST_IDLE;
      end
      ST_TXT_UPD: begin
        cnt_ctl.wr_en = 1'b1;
        cnt_wr_have   = cnt_rd_have + ONE;
        missing_nxt   = miss_dec;
        // covering: start shrinking, text read at left goes out now
        state_nxt     = (miss_dec == '0) ? ST_SHR_RD : ST_IDLE;
      end
      ST_SHR_RD: begin
        cnt_ctl.addr = txt_rdata;
        shr_sym_nxt  = txt_rdata;
        state_nxt    = ST_SHR_CHK;
      end
      ST_SHR_CHK: begin
        cnt_ctl.addr = shr_sym_r;
        if (cnt_rd_have <= cnt_rd_need) begin
          state_nxt = ST_RECORD;
        end else begin
          cnt_ctl.wr_en = 1'b1;
          cnt_wr_have   = cnt_rd_have - ONE;
          left_nxt      = left_inc;
          txt_raddr     = left_inc[AW-1:0];
          state_nxt     = (left_inc < right_r) ? ST_SHR_RD : ST_RECORD;
        end
      end
      ST_RECORD: begin
        // strictly shorter only, so the earliest start wins ties
        if (!best_valid_r || (win_len < best_len_r)) begin
          best_valid_nxt = 1'b1;
          best_start_nxt = left_r[AW-1:0];
          best_len_nxt   = win_len;
        end
        state_nxt = ST_IDLE;
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_take) begin
          cnt_ctl.clear  = 1'b1;
          left_nxt       = '0;
          right_nxt      = '0;
          missing_nxt    = '0;
          pat_len_nxt    = '0;
          best_start_nxt = '0;
          best_len_nxt   = '0;
          best_valid_nxt = 1'b0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // best fields stay zero while no window was recorded
  assign start_ext    = {START_W'(0), best_start_r};
  assign len_ext      = {LEN_W'(0), best_len_r};
  assign res_found    = (pat_len_r == '0) || best_valid_r;
  assign res_start    = start_ext[START_W-1:0];
  assign res_len      = len_ext[LEN_W-1:0];
  assign res_overflow = ovf_r;

endmodule

/* rtl/minimum_window_cover.sv */
// minimum_window_cover: shortest window of a byte text covering a pattern.
// steps: pattern beat taken in idle, then counted; text beat stored, then
// counted if a pattern is set; once covering, left checks (text read, count
// check), then record. intake: one beat at a time, set by the single count
// table port; each covered text byte leaves the window once
// reset: control and count table cleared at once via valid flags, text kept
module minimum_window_cover import mwc_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // mode[1:0], symbol[9:2], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // found[0], window_start[12:1],
                                            // window_length[25:13],
                                            // overflow[26], zero pad
);

  localparam int CNT_W = $clog2(MAX_TEXT + 1);
  localparam int AW    = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

  // count table port
  cnt_ctl_t         cnt_ctl;
  logic [CNT_W-1:0] cnt_wr_need;
  logic [CNT_W-1:0] cnt_wr_have;
  logic [CNT_W-1:0] cnt_rd_need;
  logic [CNT_W-1:0] cnt_rd_have;

  // text buffer port
  logic             txt_we;
  logic [AW-1:0]    txt_waddr;
  sym_t             txt_wdata;
  logic [AW-1:0]    txt_raddr;
  sym_t             txt_rdata;

  // finished result from the sequencer
  logic               res_valid;
  logic               res_take;
  logic               res_found;
  logic [START_W-1:0] res_start;
  logic [LEN_W-1:0]   res_len;
  logic               res_overflow;

  // output register, separates result delivery from item intake
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [START_W-1:0] out_start_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_ovf_r;
  logic               out_load;

  mwc_seq #(
    .MAX_TEXT (MAX_TEXT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_mode      (in_tdata[MODE_W-1:0]),
    .in_sym       (in_tdata[MODE_W+SYM_W-1:MODE_W]),
    .in_ready     (in_tready),
    .cnt_ctl      (cnt_ctl),
    .cnt_wr_need  (cnt_wr_need),
    .cnt_wr_have  (cnt_wr_have),
    .cnt_rd_need  (cnt_rd_need),
    .cnt_rd_have  (cnt_rd_have),
    .txt_we       (txt_we),
    .txt_waddr    (txt_waddr),
    .txt_wdata    (txt_wdata),
    .txt_raddr    (txt_raddr),
    .txt_rdata    (txt_rdata),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_found    (res_found),
    .res_start    (res_start),
    .res_len      (res_len),
    .res_overflow (res_overflow)
  );

  mwc_cnt_tbl #(
    .MAX_TEXT (MAX_TEXT)
  ) u_cnt_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cnt_ctl),
    .wr_need (cnt_wr_need),
    .wr_have (cnt_wr_have),
    .rd_need (cnt_rd_need),
    .rd_have (cnt_rd_have)
  );

  mwc_text_buf #(
    .MAX_TEXT (MAX_TEXT)
  ) u_text_buf (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_waddr),
    .wdata (txt_wdata),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  // result moves in when the register is empty or drains this cycle
  assign res_take = !out_valid_r || out_tready;
  assign out_load = res_valid && res_take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found;
      out_start_r <= res_start;
      out_len_r   <= res_len;
      out_ovf_r   <= res_overflow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 - START_W - LEN_W){1'b0}},
                       out_ovf_r, out_len_r, out_start_r, out_found_r};

endmodule

/* test/mwc_cover_checker.sv */
// mwc_cover_checker: watches both streams of minimum_window_cover, predicts
// every finish report from the accepted beats and compares it field by field
// depends on mwc_pkg for widths and item kinds
module mwc_cover_checker import mwc_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               ovf;
  } cover_rpt_t;

  // job state of the predictor
  logic [LEN_W-1:0]   need_cnt [SYM_N];
  logic [LEN_W-1:0]   have_cnt [SYM_N];
  sym_t               text_buf [MAX_TEXT];
  logic [LEN_W-1:0]   lo_idx, hi_idx, missing, pat_len, best_len;
  logic [START_W-1:0] best_start;
  logic               best_ok, ovf_seen;
  cover_rpt_t         report_q[$];

  function automatic void clear_job();
    foreach (need_cnt[i]) begin
      need_cnt[i] = '0;
      have_cnt[i] = '0;
    end
    lo_idx     = '0;
    hi_idx     = '0;
    missing    = '0;
    pat_len    = '0;
    best_len   = '0;
    best_start = '0;
    best_ok    = 1'b0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void take_pattern(sym_t s);
    // late pattern bytes are dropped once text has started
    if (hi_idx != 0) return;
    if (pat_len >= MAX_TEXT) begin
      ovf_seen = 1'b1;
      return;
    end
    pat_len++;
    need_cnt[s]++;
    missing++;
  endfunction

  function automatic void take_text(sym_t s);
    sym_t b;
    if (hi_idx >= MAX_TEXT) begin
      ovf_seen = 1'b1;
      return;
    end
    text_buf[hi_idx] = s;
    hi_idx++;
    if (pat_len == 0) return;
    if (have_cnt[s] < need_cnt[s]) missing--;
    have_cnt[s]++;
    if (missing != 0) return;
    // shrink from the left while the window still covers
    while (lo_idx < hi_idx) begin
      b = text_buf[lo_idx];
      if (have_cnt[b] <= need_cnt[b]) break;
      have_cnt[b]--;
      lo_idx++;
    end
    // strictly shorter only, so the earliest of equal windows stays
    if (!best_ok || (hi_idx - lo_idx) < best_len) begin
      best_ok    = 1'b1;
      best_start = lo_idx[START_W-1:0];
      best_len   = hi_idx - lo_idx;
    end
  endfunction

  function automatic cover_rpt_t finish_job();
    cover_rpt_t r;
    r     = '0;
    r.ovf = ovf_seen;
    if (pat_len == 0) begin
      r.found = 1'b1;
    end else if (best_ok) begin
      r.found  = 1'b1;
      r.start  = best_start;
      r.length = best_len;
    end
    clear_job();
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_report(logic [OUT_DATA_W-1:0] d);
    cover_rpt_t want;
    if (report_q.size() == 0) begin
      flag_mismatch("report with nothing pending, data", d, 0);
      return;
    end
    want = report_q.pop_front();
    if (d[0] !== want.found)
      flag_mismatch("found", d[0], want.found);
    if (d[START_W:1] !== want.start)
      flag_mismatch("window_start", d[START_W:1], want.start);
    if (d[START_W+LEN_W:START_W+1] !== want.length)
      flag_mismatch("window_length", d[START_W+LEN_W:START_W+1], want.length);
    if (d[START_W+LEN_W+1] !== want.ovf)
      flag_mismatch("overflow", d[START_W+LEN_W+1], want.ovf);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_job();
      report_q.delete();
    end else begin
      // older report first, a finish beat on this edge cannot be answered yet
      if (out_tvalid && out_tready) check_report(out_tdata);
      if (in_tvalid && in_tready) begin
        case (in_tdata[MODE_W-1:0])
          MODE_PATTERN: take_pattern(in_tdata[MODE_W +: SYM_W]);
          MODE_TEXT:    take_text(in_tdata[MODE_W +: SYM_W]);
          MODE_FINISH:  report_q.insert(report_q.size(), finish_job());
          default: ;
        endcase
      end
    end
    pending_reports <= report_q.size();
  end

endmodule

/* test/tb_minimum_window_cover.sv */
// tb_minimum_window_cover: stimulus and verdict for minimum_window_cover
// depends on mwc_pkg, the block itself and mwc_cover_checker
module tb_minimum_window_cover import mwc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // kind the block has no use for, it must be swallowed without a report
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // a single text byte may trigger a full-buffer shrink
  localparam int STALL_LIMIT  = 50000;
  localparam int RANDOM_BEATS = 1200;
  localparam int CALM_AFTER   = 950;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // mode[1:0], symbol[9:2], zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // found[0], window_start[12:1],
                                            // window_length[25:13],
                                            // overflow[26], zero pad
  int                    fails;
  int                    pending;
  int                    beats_sent = 0;
  int                    quiet_cycles = 0;
  bit                    calm = 1'b0;       // no idling on either side once set

  minimum_window_cover dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mwc_cover_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fails),
    .pending_reports (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one input beat; returns in the time step of the edge that took it,
  // so the next call can keep tvalid high without dropping it
  task automatic send_beat(logic [MODE_W-1:0] m, sym_t s);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - MODE_W - SYM_W){1'b0}}, s, m};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // the symbol of a finish beat is don't-care, so it is random as well
  task automatic close_job();
    send_beat(MODE_FINISH, SYM_W'($urandom_range(0, 255)));
  endtask

  // mostly well-formed jobs over a narrow alphabet so covers are common,
  // with now and then an unused kind, a late pattern byte or pure noise
  task automatic random_job();
    int   k;
    int   n_pat;
    int   n_txt;
    sym_t base;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30))
        send_beat(MODE_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
      return;
    end
    k     = $urandom_range(1, 6);
    base  = SYM_W'($urandom_range(0, 255));
    n_pat = $urandom_range(0, 5);
    n_txt = $urandom_range(0, 30);
    repeat (n_pat) send_beat(MODE_PATTERN, SYM_W'(base + $urandom_range(0, k - 1)));
    repeat (n_txt) begin
      if ($urandom_range(0, 24) == 0)
        send_beat(MODE_UNUSED, SYM_W'($urandom_range(0, 255)));
      else if ($urandom_range(0, 24) == 0)
        send_beat(MODE_PATTERN, SYM_W'(base + $urandom_range(0, k - 1)));
      send_beat(MODE_TEXT, SYM_W'(base + $urandom_range(0, k - 1)));
    end
    close_job();
  endtask

  // result side: ready drops in random bursts until the calm stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // watchdog: too long without any beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int start_count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty job: no pattern at all reports found with length zero
    close_job();

    // extreme symbols, an unused kind mid-text and a late pattern byte
    send_beat(MODE_PATTERN, 8'h00);
    send_beat(MODE_PATTERN, 8'hFF);
    send_beat(MODE_TEXT,    8'hFF);
    send_beat(MODE_UNUSED,  8'hA5);
    send_beat(MODE_TEXT,    8'h10);
    send_beat(MODE_PATTERN, 8'h10);
    send_beat(MODE_TEXT,    8'h00);
    close_job();

    // repeated pattern byte never covered: found clear
    send_beat(MODE_PATTERN, 8'h41);
    send_beat(MODE_PATTERN, 8'h41);
    send_beat(MODE_TEXT,    8'h41);
    send_beat(MODE_TEXT,    8'h42);
    close_job();

    // two windows of equal length: the earlier one must be kept
    send_beat(MODE_PATTERN, 8'h61);
    send_beat(MODE_PATTERN, 8'h62);
    send_beat(MODE_TEXT,    8'h61);
    send_beat(MODE_TEXT,    8'h62);
    send_beat(MODE_TEXT,    8'h61);
    send_beat(MODE_TEXT,    8'h62);
    close_job();

    // text with an empty pattern still counts as found, length zero
    send_beat(MODE_TEXT, 8'h33);
    send_beat(MODE_TEXT, 8'h44);
    close_job();

    // random jobs; the last stretch runs without idling
    start_count = beats_sent;
    while (beats_sent - start_count < RANDOM_BEATS) begin
      if (beats_sent - start_count >= CALM_AFTER) calm = 1'b1;
      random_job();
    end
    close_job();
    in_tvalid <= 1'b0;

    // let the checker see the last beat, then wait for the reports
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
